// ===== sv/bloom_filter_membership_defines.svh =====
// Assertion macros used by the bloom filter membership RTL.
`ifndef BLOOM_FILTER_MEMBERSHIP_DEFINES_SVH
`define BLOOM_FILTER_MEMBERSHIP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BFM_ASSERT_IMPL(name, cond, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (expr)) \
    else $error("bfm: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BFM_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("bfm: next-cycle check failed");

`endif

// ===== sv/bfm_pkg.sv =====
// Shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
package bfm_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_BITS   = 4096;
  localparam int unsigned DEF_MAX_HASHES = 16;

  // configuration register widths and reset values
  localparam int unsigned BIT_COUNT_W  = 13;
  localparam int unsigned HASH_COUNT_W = 5;
  localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 13'd4096;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd3;

  // register select (word address bit)
  localparam logic REG_BIT_COUNT  = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  // opcode values
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // bits consumed per remainder step
  localparam int unsigned STEP_BITS = 4;

  typedef struct packed {
    logic clr;     // clear one bit store entry
    logic load;    // take a beat and form the raw sums
    logic step;    // one remainder step on both sums
    logic commit;  // store reduced sums or start probing
    logic wr;      // set the bit at the current index
    logic adv;     // move to the next index
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;  // last entry of clearing pass
    logic last;      // latched end-of-entry flag
    logic op;        // latched opcode
    logic rd_bit;    // bit store read data
  } dp_sts_t;

endpackage

// ===== sv/bfm_dp.sv =====
// Datapath: running sums, remainder engine, index generator and bit store.
`timescale 1ns / 1ps
module bfm_dp #(
  parameter int unsigned MAX_BITS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [$clog2(MAX_BITS):0]     m_i,
  input  logic                          opcode_i,
  input  logic [7:0]                    first_digest_byte_i,
  input  logic [7:0]                    second_digest_low_i,
  input  logic [7:0]                    second_digest_high_i,
  input  logic                          end_of_entry_i,
  input  bfm_pkg::dp_cmd_t              cmd_i,
  output bfm_pkg::dp_sts_t              sts_o,
  output logic                          was_query_o
);
  import bfm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BITS);
  localparam int unsigned MW = IW + 1;
  localparam int unsigned VW = $clog2(MAX_BITS + 512);
  localparam int unsigned NS = (VW + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PW = NS * STEP_BITS;

  logic [IW-1:0] sum1_q, sum2_q;
  logic [PW-1:0] v1_q, v2_q;
  logic [IW-1:0] r1_q, r2_q;
  logic [IW-1:0] x_q, y_q, im_q;
  logic [IW-1:0] clr_q;
  logic          op_q, last_q;
  logic          rd_q;
  logic          mem_q [MAX_BITS];

  logic [IW:0]   xy_sum, yi_sum, im_inc;

  // restoring remainder over STEP_BITS new bits, r < m throughout
  function automatic logic [IW-1:0] rem_step(input logic [IW-1:0] r,
                                             input logic [STEP_BITS-1:0] bits,
                                             input logic [MW-1:0] m);
    logic [MW:0]   t;
    logic [IW-1:0] a;
    a = r;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {1'b0, a, bits[STEP_BITS-1-j]};
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      a = t[IW-1:0];
    end
    return a;
  endfunction

  // next index terms, each operand below m
  assign xy_sum = {1'b0, x_q} + {1'b0, y_q};
  assign yi_sum = {1'b0, y_q} + {1'b0, im_q};
  assign im_inc = {1'b0, im_q} + MW'(1);

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q <= '0;
      sum2_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + IW'(1);
      if (cmd_i.commit) begin
        if (last_q) begin
          sum1_q <= '0;
          sum2_q <= '0;
        end else begin
          sum1_q <= r1_q;
          sum2_q <= r2_q;
        end
      end
    end
  end

  // sum reduction and index generation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v1_q   <= PW'(sum1_q) + PW'(first_digest_byte_i);
      v2_q   <= PW'(sum2_q) + PW'(second_digest_low_i) + PW'(second_digest_high_i);
      r1_q   <= '0;
      r2_q   <= '0;
      op_q   <= opcode_i;
      last_q <= end_of_entry_i;
    end else if (cmd_i.step) begin
      r1_q <= rem_step(r1_q, v1_q[PW-1 -: STEP_BITS], m_i);
      r2_q <= rem_step(r2_q, v2_q[PW-1 -: STEP_BITS], m_i);
      v1_q <= v1_q << STEP_BITS;
      v2_q <= v2_q << STEP_BITS;
    end
    if (cmd_i.commit) begin
      x_q  <= r1_q;
      y_q  <= r2_q;
      im_q <= (m_i == MW'(1)) ? '0 : IW'(1);
    end else if (cmd_i.adv) begin
      x_q  <= (xy_sum >= m_i) ? IW'(xy_sum - m_i) : xy_sum[IW-1:0];
      y_q  <= (yi_sum >= m_i) ? IW'(yi_sum - m_i) : yi_sum[IW-1:0];
      im_q <= (im_inc == m_i) ? '0 : im_inc[IW-1:0];
    end
  end

  // bit store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mem_q[clr_q] <= 1'b0;
    else if (cmd_i.wr) mem_q[x_q] <= 1'b1;
    rd_q <= mem_q[x_q];
  end

  assign sts_o.clr_last = (clr_q == IW'(MAX_BITS - 1));
  assign sts_o.last     = last_q;
  assign sts_o.op       = op_q;
  assign sts_o.rd_bit   = rd_q;
  assign was_query_o    = op_q;

endmodule

// ===== sv/bfm_ctrl.sv =====
// Controller: clearing pass, reduction steps and probe sequencing.
`timescale 1ns / 1ps
`include "bloom_filter_membership_defines.svh"
module bfm_ctrl #(
  parameter int unsigned MAX_HASHES = 16,
  parameter int unsigned RED_STEPS  = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [$clog2(MAX_HASHES+1)-1:0]    k_i,
  input  bfm_pkg::dp_sts_t                   sts_i,
  output bfm_pkg::dp_cmd_t                   cmd_o,
  output logic                               busy_o,
  output logic                               done_o,
  output logic                               found_o
);
  import bfm_pkg::*;

  localparam int unsigned KW  = $clog2(MAX_HASHES + 1);
  localparam int unsigned SCW = $clog2(RED_STEPS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_REDUCE, ST_COMMIT, ST_PROBE, ST_CHECK
  } state_e;

  state_e         state_q;
  logic           busy_q, done_q, found_q;
  logic [SCW-1:0] step_q;
  logic [KW-1:0]  i_q;
  logic           last_probe;

  assign last_probe = ((i_q + KW'(1)) == k_i);

  // commands to the datapath
  always_comb begin
    cmd_o        = '0;
    cmd_o.clr    = (state_q == ST_CLEAR);
    cmd_o.load   = (state_q == ST_IDLE) && start_i;
    cmd_o.step   = (state_q == ST_REDUCE);
    cmd_o.commit = (state_q == ST_COMMIT);
    cmd_o.wr     = (state_q == ST_PROBE) && (sts_i.op == OP_ADD);
    cmd_o.adv    = ((state_q == ST_PROBE) && (sts_i.op == OP_ADD)) ||
                   ((state_q == ST_CHECK) && sts_i.rd_bit);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      step_q  <= '0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_REDUCE;
            busy_q  <= 1'b1;
            step_q  <= '0;
          end
        end
        ST_REDUCE: begin
          step_q <= step_q + SCW'(1);
          if (step_q == SCW'(RED_STEPS - 1)) state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          i_q <= '0;
          if (!sts_i.last) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end else if (k_i == '0) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
            found_q <= 1'b1;
          end else begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (sts_i.op == OP_QUERY) begin
            state_q <= ST_CHECK;
          end else if (last_probe) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
            found_q <= 1'b1;
          end else begin
            i_q <= i_q + KW'(1);
          end
        end
        ST_CHECK: begin
          if (!sts_i.rd_bit || last_probe) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
            found_q <= sts_i.rd_bit;
          end else begin
            state_q <= ST_PROBE;
            i_q     <= i_q + KW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign found_o = found_q;

  // checks
  `BFM_ASSERT_IMPL(a_done_when_idle, done_q, !busy_q && state_q == ST_IDLE)
  `BFM_ASSERT_NEXT(a_accept_sets_busy, start_i && !busy_q, busy_q)
  `BFM_ASSERT_NEXT(a_done_single, done_q, !done_q)
  `BFM_ASSERT_IMPL(a_ready_only_idle, !busy_q, state_q == ST_IDLE)

endmodule

// ===== sv/bloom_filter_membership.sv =====
// Top level: configuration registers, controller and datapath.
//
// Bloom filter membership over two upstream digests.
// Beats enter on start when busy is low; each carries one byte of the first
// digest, bytes i and i+32 of the second, the opcode and end_of_entry.
// Each beat is loaded, then a 4-bit-per-cycle remainder unit reduces both
// running sums modulo m; busy stays high until the beat is done.
// On the end_of_entry beat, the k indices follow by enhanced double hashing
// through the bit store: an add sets one bit per cycle, a query reads each
// bit and checks the registered read, stopping at the first clear bit.
// The result shows on found_o / was_query_o with done_o high for one cycle,
// the cycle in which busy drops again; the receiver cannot stall it.
// After reset, busy stays high while the bit store is cleared one entry a
// cycle; registers take APB writes throughout.
// Registers: bit_count at 0x0 (m, reset 4096), hash_count at 0x4 (k, reset 3).
// Write them only while the block is idle.
`timescale 1ns / 1ps
module bloom_filter_membership #(
  parameter int unsigned MAX_BITS   = bfm_pkg::DEF_MAX_BITS,
  parameter int unsigned MAX_HASHES = bfm_pkg::DEF_MAX_HASHES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [7:0]  first_digest_byte_i,
  input  logic [7:0]  second_digest_low_i,
  input  logic [7:0]  second_digest_high_i,
  input  logic        end_of_entry_i,
  output logic        done_o,
  output logic        found_o,
  output logic        was_query_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfm_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BITS);
  localparam int unsigned MW = IW + 1;
  localparam int unsigned KW = $clog2(MAX_HASHES + 1);
  localparam int unsigned VW = $clog2(MAX_BITS + 512);
  localparam int unsigned NS = (VW + STEP_BITS - 1) / STEP_BITS;

  logic [BIT_COUNT_W-1:0]  bit_count_q;
  logic [HASH_COUNT_W-1:0] hash_count_q;
  logic [MW-1:0]           m_eff;
  logic [KW-1:0]           k_eff;
  logic                    cfg_wr;
  dp_cmd_t                 cmd;
  dp_sts_t                 sts;

  // APB register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q  <= BIT_COUNT_RST;
      hash_count_q <= HASH_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BIT_COUNT) bit_count_q <= pwdata[BIT_COUNT_W-1:0];
      else hash_count_q <= pwdata[HASH_COUNT_W-1:0];
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_BIT_COUNT:  prdata = 32'(bit_count_q);
      REG_HASH_COUNT: prdata = 32'(hash_count_q);
      default:        prdata = '0;
    endcase
  end

  // effective m and k: zero m acts as one, both saturate at their maximum
  always_comb begin
    if (bit_count_q == '0) m_eff = MW'(1);
    else if (32'(bit_count_q) > MAX_BITS) m_eff = MW'(MAX_BITS);
    else m_eff = MW'(bit_count_q);
    if (32'(hash_count_q) > MAX_HASHES) k_eff = KW'(MAX_HASHES);
    else k_eff = KW'(hash_count_q);
  end

  bfm_ctrl #(
    .MAX_HASHES (MAX_HASHES),
    .RED_STEPS  (NS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .k_i     (k_eff),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o),
    .found_o (found_o)
  );

  bfm_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .m_i                  (m_eff),
    .opcode_i             (opcode_i),
    .first_digest_byte_i  (first_digest_byte_i),
    .second_digest_low_i  (second_digest_low_i),
    .second_digest_high_i (second_digest_high_i),
    .end_of_entry_i       (end_of_entry_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .was_query_o          (was_query_o)
  );

endmodule

// ===== dv/bloom_filter_membership_test.sv =====
// Self-checking testbench for the bloom filter membership block.
`timescale 1ns / 1ps
module bloom_filter_membership_test;
  import bfm_pkg::*;

  // Membership scoreboard: mirrors the bit store and both running sums.
  class membership_scoreboard;
    bit          filter_bits [4096];
    int unsigned sum_first;
    int unsigned sum_second;
    int unsigned bits_reg;
    int unsigned hashes_reg;
    bit          want_found [$];
    bit          want_query [$];
    int          errors;

    function void clear_all();
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      sum_first = 0;
      sum_second = 0;
      bits_reg = 4096;
      hashes_reg = 3;
      errors = 0;
    endfunction

    // Fold one accepted beat into the sums; at entry end, probe or set.
    function void note_beat(bit op, bit [7:0] b1, bit [7:0] b2, bit [7:0] b3, bit eoe);
      int unsigned m;
      int unsigned k;
      int unsigned x;
      int unsigned y;
      bit hit;
      m = (bits_reg == 0) ? 1 : (bits_reg > 4096 ? 4096 : bits_reg);
      k = (hashes_reg > 16) ? 16 : hashes_reg;
      sum_first = (sum_first % m + b1 % m) % m;
      sum_second = (sum_second % m + b2 % m + b3 % m) % m;
      if (!eoe) return;
      x = sum_first;
      y = sum_second;
      hit = 1'b1;
      for (int unsigned i = 0; i < k; i++) begin
        if (i > 0) begin
          x = (x + y) % m;
          y = (y + i) % m;
        end
        if (op == OP_QUERY) begin
          if (!filter_bits[x % 4096]) begin
            hit = 1'b0;
            break;
          end
        end else begin
          filter_bits[x % 4096] = 1'b1;
        end
      end
      sum_first = 0;
      sum_second = 0;
      want_found.push_back(op == OP_QUERY ? hit : 1'b1);
      want_query.push_back(op);
    endfunction

    function void check_result(bit found, bit was_query);
      if (want_found.size() == 0) begin
        $display("%0t: unexpected result found=%0b was_query=%0b", $realtime, found,
                 was_query);
        errors++;
        return;
      end
      if (found !== want_found[0]) begin
        $display("%0t: found expected %0b actual %0b", $realtime, want_found[0], found);
        errors++;
      end
      if (was_query !== want_query[0]) begin
        $display("%0t: was_query expected %0b actual %0b", $realtime, want_query[0],
                 was_query);
        errors++;
      end
      void'(want_found.pop_front());
      void'(want_query.pop_front());
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = 1'b0;
  logic [7:0]  first_digest_byte_i = '0;
  logic [7:0]  second_digest_low_i = '0;
  logic [7:0]  second_digest_high_i = '0;
  logic        end_of_entry_i = 1'b0;
  logic        done_o;
  logic        found_o;
  logic        was_query_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  membership_scoreboard filter_sb;

  bloom_filter_membership dut (.*);

  always #2 clk_i = ~clk_i;

  // Results cannot be stalled: check every done strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) filter_sb.check_result(found_o, was_query_o);
  end

  // Hard limit on run time.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // Mostly short gaps, now and then a long one, sometimes none.
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) < 4) ? 0 :
        (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (n != 0) start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // One beat: hold start until the block takes it; start stays up for a following beat.
  task automatic send_beat(bit op, bit [7:0] b1, bit [7:0] b2, bit [7:0] b3, bit eoe);
    start <= 1'b1;
    opcode_i <= op;
    first_digest_byte_i <= b1;
    second_digest_low_i <= b2;
    second_digest_high_i <= b3;
    end_of_entry_i <= eoe;
    do @(posedge clk_i); while (busy !== 1'b0);
    filter_sb.note_beat(op, b1, b2, b3, eoe);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (filter_sb.want_found.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Register write, setup then access; only when idle.
  task automatic reg_write(logic sel, int unsigned value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_BIT_COUNT) filter_sb.bits_reg = value & 32'h1FFF;
    else filter_sb.hashes_reg = value & 32'h1F;
  endtask

  task automatic send_entry(bit op, int unsigned len, bit gaps);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(($urandom_range(0, 1) == 1), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
      if (gaps) idle_gap();
    end
    send_beat(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 1'b1);
    if (gaps) idle_gap();
  endtask

  initial begin
    int unsigned bit_setting [6] = '{4096, 1, 0, 8191, 37, 1000};
    int unsigned hash_setting [6] = '{3, 16, 0, 31, 1, 7};
    int unsigned beats;
    filter_sb = new();
    filter_sb.clear_all();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes in a two-beat entry, add then query of the same content, single-beat entries.
    send_beat(OP_ADD, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_beat(OP_QUERY, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_beat(OP_ADD, 8'h00, 8'h00, 8'h00, 1'b1);
    send_beat(OP_QUERY, 8'h00, 8'h00, 8'h00, 1'b1);
    send_beat(OP_QUERY, 8'hAA, 8'h55, 8'h0F, 1'b1);
    send_beat(OP_ADD, 8'h55, 8'hAA, 8'hF0, 1'b1);
    send_beat(OP_QUERY, 8'h55, 8'hAA, 8'hF0, 1'b1);
    // A nominal 32-beat entry and a 41-beat one; lengths are unenforced.
    send_entry(OP_ADD, 31, 1'b0);
    send_entry(OP_QUERY, 40, 1'b0);

    // Random phases across register settings, extremes included.
    beats = 0;
    for (int p = 0; p < 6; p++) begin
      reg_write(REG_BIT_COUNT, bit_setting[p]);
      reg_write(REG_HASH_COUNT, hash_setting[p]);
      while (beats < (p + 1) * 128) begin
        int unsigned len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_entry(($urandom_range(0, 2) != 0), len, 1'b1);
        beats += len + 1;
        // Now and then hold off until all results are in.
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    if (filter_sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
